FILE: design/flow_reference_counter_table_unit_defines.svh
`ifndef FLOW_REFERENCE_COUNTER_TABLE_UNIT_DEFINES_SVH
`define FLOW_REFERENCE_COUNTER_TABLE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define FRCT_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FRCT_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/frct_pkg.sv
package frct_pkg;

	localparam int ENTRIES = 256;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	localparam int MODE_W  = 2;
	localparam int ADDR_W  = 32;
	localparam int PORT_W  = 16;
	localparam int KEY_W   = ADDR_W + PORT_W;
	localparam int COUNT_W = 16;
	localparam int STAT_W  = 2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DEL   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
	localparam logic [STAT_W-1:0] ST_SAT    = 2'd2;
	localparam logic [STAT_W-1:0] ST_ABSENT = 2'd3;

	// request token walking the cell chain
	typedef struct packed {
		logic                vld;
		logic [MODE_W-1:0]   mode;
		logic [KEY_W-1:0]    key;
		logic                found;
		logic                sat;
		logic                free_seen;
		logic [IDX_W-1:0]    free_idx;
		logic [COUNT_W-1:0]  count;
	} tok_t;

	// new-entry write broadcast from the chain end
	typedef struct packed {
		logic                vld;
		logic [IDX_W-1:0]    idx;
		logic [KEY_W-1:0]    key;
	} alloc_t;

endpackage

FILE: design/frct_req_if.sv
interface frct_req_if;
	import frct_pkg::*;

	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [ADDR_W-1:0]   flow_addr;
	logic [PORT_W-1:0]   flow_port;

	modport source (output valid, mode, flow_addr, flow_port, input ready);
	modport sink   (input valid, mode, flow_addr, flow_port, output ready);
endinterface

FILE: design/frct_rsp_if.sv
interface frct_rsp_if;
	import frct_pkg::*;

	logic                valid;
	logic                ready;
	logic [COUNT_W-1:0]  count;
	logic [STAT_W-1:0]   status;

	modport source (output valid, count, status, input ready);
	modport sink   (input valid, count, status, output ready);
endinterface

FILE: design/frct_cell.sv
`include "flow_reference_counter_table_unit_defines.svh"

module frct_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [frct_pkg::IDX_W-1:0] idx,
	input  frct_pkg::tok_t        tok_i,
	input  frct_pkg::alloc_t      alloc,
	output frct_pkg::tok_t        tok_o
);
	import frct_pkg::*;

	logic               valid_q;
	logic [KEY_W-1:0]   key_q;
	logic [COUNT_W-1:0] count_q;
	tok_t               tok_q;

	logic               hit;
	logic               take_alloc;
	logic               wr_count;
	logic               clr_valid;
	logic [COUNT_W-1:0] new_count;
	tok_t               nxt;

	assign hit        = tok_i.vld && !tok_i.found && valid_q && (key_q == tok_i.key);
	assign take_alloc = alloc.vld && (alloc.idx == idx);

	always_comb begin
		nxt       = tok_i;
		wr_count  = 1'b0;
		clr_valid = 1'b0;
		new_count = count_q;
		if (hit) begin
			nxt.found = 1'b1;
			case (tok_i.mode)
				MODE_ADD: begin
					if (count_q == COUNT_MAX) begin
						nxt.count = COUNT_MAX;
						nxt.sat   = 1'b1;
					end else begin
						new_count = count_q + COUNT_W'(1);
						wr_count  = 1'b1;
						nxt.count = new_count;
					end
				end
				MODE_DEL: begin
					if (count_q <= COUNT_W'(1)) begin
						new_count = '0;
						wr_count  = 1'b1;
						clr_valid = 1'b1;
						nxt.count = '0;
					end else begin
						new_count = count_q - COUNT_W'(1);
						wr_count  = 1'b1;
						nxt.count = new_count;
					end
				end
				default: nxt.count = count_q;
			endcase
		end
		if (tok_i.vld && !tok_i.free_seen && !valid_q) begin
			nxt.free_seen = 1'b1;
			nxt.free_idx  = idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= '0;
		end else begin
			tok_q <= nxt;
			if (take_alloc) begin
				valid_q <= 1'b1;
			end else if (clr_valid) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_alloc) begin
			key_q   <= alloc.key;
			count_q <= COUNT_W'(1);
		end else if (wr_count) begin
			count_q <= new_count;
		end
	end

	assign tok_o = tok_q;

	`FRCT_ASSERT_NOW(a_alloc_free_only, take_alloc, !valid_q, "allocation into a live entry")
	`FRCT_ASSERT_NOW(a_alloc_no_token, take_alloc, !tok_i.vld, "allocation while a token is in the chain")
	`FRCT_ASSERT_NEXT(a_del_frees, hit && clr_valid && !take_alloc, !valid_q, "delete to zero kept entry")

endmodule

FILE: design/flow_reference_counter_table_unit.sv
// channel | dir | payload                          | handshake
// req     | in  | mode, flow_addr, flow_port       | valid/ready
// rsp     | out | count, status                    | valid/ready
//
// A transaction walks the chain of ENTRIES cells, one cell per cycle, and its
// result then passes the hold stage into rsp before a new request is accepted.
// One request in flight; the next is accepted while the last result waits in rsp.
// Reset clears all entry valid marks at once; no clearing pass.
// A stalled rsp holds its result; a further finished result waits in a hold stage.

`include "flow_reference_counter_table_unit_defines.svh"

module flow_reference_counter_table_unit (
	input  logic       clk,
	input  logic       arst_n,
	frct_req_if.sink   req,
	frct_rsp_if.source rsp
);
	import frct_pkg::*;

	tok_t               tok [ENTRIES+1];
	logic [ENTRIES-1:0] tok_vld;
	alloc_t             alloc;
	tok_t               last;

	logic               busy_q;
	logic               fin_vld_q;
	logic [COUNT_W-1:0] fin_count_q;
	logic [STAT_W-1:0]  fin_status_q;
	logic               out_vld_q;
	logic [COUNT_W-1:0] out_count_q;
	logic [STAT_W-1:0]  out_status_q;

	logic               accept;
	logic               fin_move;
	logic [COUNT_W-1:0] res_count;
	logic [STAT_W-1:0]  res_status;

	assign req.ready = !busy_q;
	assign accept    = req.valid && req.ready;

	assign tok[0] = '{vld: accept, mode: req.mode, key: {req.flow_addr, req.flow_port},
		default: '0};

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		frct_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (IDX_W'(i)),
			.tok_i  (tok[i]),
			.alloc  (alloc),
			.tok_o  (tok[i+1])
		);
		assign tok_vld[i] = tok[i+1].vld;
	end

	assign last = tok[ENTRIES];

	always_comb begin
		alloc.vld = last.vld && (last.mode == MODE_ADD) && !last.found && last.free_seen;
		alloc.idx = last.free_idx;
		alloc.key = last.key;
	end

	always_comb begin
		if (last.found) begin
			res_count  = last.count;
			res_status = last.sat ? ST_SAT : ST_OK;
		end else if (last.mode == MODE_ADD) begin
			res_count  = last.free_seen ? COUNT_W'(1) : '0;
			res_status = last.free_seen ? ST_OK : ST_FULL;
		end else begin
			res_count  = '0;
			res_status = ST_ABSENT;
		end
	end

	assign fin_move = fin_vld_q && (!out_vld_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			fin_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (fin_move) begin
				busy_q <= 1'b0;
			end
			if (last.vld) begin
				fin_vld_q <= 1'b1;
			end else if (fin_move) begin
				fin_vld_q <= 1'b0;
			end
			if (fin_move) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (last.vld) begin
			fin_count_q  <= res_count;
			fin_status_q <= res_status;
		end
		if (fin_move) begin
			out_count_q  <= fin_count_q;
			out_status_q <= fin_status_q;
		end
	end

	assign rsp.valid  = out_vld_q;
	assign rsp.count  = out_count_q;
	assign rsp.status = out_status_q;

	`FRCT_ASSERT_NOW(a_one_token, 1'b1, $onehot0(tok_vld), "more than one token in the chain")
	`FRCT_ASSERT_NOW(a_no_overwrite, last.vld, !fin_vld_q, "finished result overwritten")
	`FRCT_ASSERT_NOW(a_idle_empty, !busy_q, (tok_vld == '0) && !fin_vld_q, "work left while idle")
	`FRCT_ASSERT_NEXT(a_accept_busy, accept, busy_q && !req.ready, "accept did not mark busy")

endmodule

FILE: test/flow_reference_counter_table_unit_test.sv
module flow_reference_counter_table_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import frct_pkg::*;

	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
	localparam int ITEMS = 1100;
	localparam int POOL = 24;
	localparam int LONG_HOLD = 1500;
	localparam int PRINT_CAP = 40;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [STAT_W-1:0]  status;
	} flow_result_t;

	class flow_table_board;
		logic [KEY_W-1:0]   slot_key [ENTRIES];
		logic [COUNT_W-1:0] slot_count [ENTRIES];
		bit                 slot_used [ENTRIES];
		flow_result_t       pending_results [$];
		int occupancy;
		int peak_occupancy;
		int requests;
		int results;
		int errors;
		int status_seen [4];

		function new();
			foreach (slot_used[i]) begin
				slot_used[i] = 1'b0;
				slot_key[i] = '0;
				slot_count[i] = '0;
			end
			foreach (status_seen[i])
				status_seen[i] = 0;
			occupancy = 0;
			peak_occupancy = 0;
			requests = 0;
			results = 0;
			errors = 0;
		endfunction

		task report(string what);
			if (errors < PRINT_CAP)
				$display("[%0t] mismatch: %s", $realtime, what);
			errors++;
		endtask

		// lowest matching slot, lowest free slot
		function void note_request(logic [MODE_W-1:0] mode, logic [ADDR_W-1:0] addr,
				logic [PORT_W-1:0] port);
			logic [KEY_W-1:0] key;
			int hit;
			int free_slot;
			flow_result_t r;
			key = {addr, port};
			hit = -1;
			free_slot = -1;
			for (int i = ENTRIES - 1; i >= 0; i--) begin
				if (slot_used[i] && slot_key[i] == key)
					hit = i;
				if (!slot_used[i])
					free_slot = i;
			end
			r.count = '0;
			r.status = ST_OK;
			case (mode)
				MODE_ADD: begin
					if (hit >= 0) begin
						if (slot_count[hit] == COUNT_MAX) begin
							r.count = COUNT_MAX;
							r.status = ST_SAT;
						end else begin
							slot_count[hit] = slot_count[hit] + 1'b1;
							r.count = slot_count[hit];
						end
					end else if (free_slot >= 0) begin
						slot_key[free_slot] = key;
						slot_count[free_slot] = COUNT_W'(1);
						slot_used[free_slot] = 1'b1;
						occupancy++;
						if (occupancy > peak_occupancy)
							peak_occupancy = occupancy;
						r.count = COUNT_W'(1);
					end else begin
						r.status = ST_FULL;
					end
				end
				MODE_DEL: begin
					if (hit < 0) begin
						r.status = ST_ABSENT;
					end else if (slot_count[hit] <= 1) begin
						slot_count[hit] = '0;
						slot_used[hit] = 1'b0;
						occupancy--;
					end else begin
						slot_count[hit] = slot_count[hit] - 1'b1;
						r.count = slot_count[hit];
					end
				end
				default: begin
					if (hit >= 0)
						r.count = slot_count[hit];
					else
						r.status = ST_ABSENT;
				end
			endcase
			requests++;
			pending_results.push_back(r);
		endfunction

		task check_result(logic [COUNT_W-1:0] count, logic [STAT_W-1:0] status);
			flow_result_t want;
			results++;
			if (pending_results.size() == 0) begin
				report($sformatf("result %0d (count %0d status %0d) with none pending",
					results, count, status));
			end else begin
				want = pending_results.pop_front();
				status_seen[want.status]++;
				if (count !== want.count)
					report($sformatf("result %0d count %0d, want %0d",
						results, count, want.count));
				if (status !== want.status)
					report($sformatf("result %0d status %0d, want %0d",
						results, status, want.status));
			end
		endtask

		function logic [KEY_W-1:0] random_live_key();
			int i;
			do
				i = $urandom_range(0, ENTRIES - 1);
			while (!slot_used[i]);
			return slot_key[i];
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	frct_req_if req_ch ();
	frct_rsp_if rsp_ch ();

	flow_reference_counter_table_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	flow_table_board sb = new();
	logic [KEY_W-1:0] flow_pool [POOL];
	bit idle_on = 1'b0;
	bit hold_now = 1'b0;
	int holds = 0;
	int drains = 0;
	int sent = 0;
	int mode_sent [4] = '{0, 0, 0, 0};

	always #1 clk = ~clk;

	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end

	// mostly back to back, some short gaps, rare long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 60)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 8);
		else
			return $urandom_range(30, 400);
	endfunction

	function automatic logic [KEY_W-1:0] fresh_key();
		return {32'($urandom), 16'($urandom)};
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_result(rsp_ch.count, rsp_ch.status);
			if (req_ch.valid && req_ch.ready)
				sb.note_request(req_ch.mode, req_ch.flow_addr, req_ch.flow_port);
		end
	end

	initial begin : rsp_side
		int n;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			n = pick_gap();
			if (hold_now) begin
				hold_now = 1'b0;
				n = LONG_HOLD;
				holds++;
			end
			if (n > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(negedge clk);
		end
	end

	// called at a falling edge; returns at a falling edge
	task automatic send_key(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key);
		int n;
		req_ch.valid <= 1'b1;
		req_ch.mode <= mode;
		req_ch.flow_addr <= key[KEY_W-1:PORT_W];
		req_ch.flow_port <= key[PORT_W-1:0];
		do
			@(posedge clk);
		while (!req_ch.ready);
		@(negedge clk);
		sent++;
		mode_sent[mode]++;
		n = pick_gap();
		if (n > 0) begin
			req_ch.valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(negedge clk);
		drains++;
	endtask

	task automatic send_mixed(input int n, input bit prefer_live);
		int r;
		logic [KEY_W-1:0] k;
		logic [MODE_W-1:0] m;
		repeat (n) begin
			if (sent % 100 == 0)
				idle_on = ((sent / 100) % 3) != 2;
			r = $urandom_range(0, 99);
			if (r < 45)
				m = prefer_live ? MODE_DEL : MODE_ADD;
			else if (r < 72)
				m = prefer_live ? MODE_ADD : MODE_DEL;
			else if (r < 95)
				m = MODE_QUERY;
			else
				m = MODE_SPARE;
			r = $urandom_range(0, 99);
			if (r < 8)
				k = fresh_key();
			else if (prefer_live && m != MODE_ADD && r < 70 && sb.occupancy > 0)
				k = sb.random_live_key();
			else
				k = flow_pool[$urandom_range(0, POOL - 1)];
			send_key(m, k);
		end
	endtask

	initial begin : stimulus
		int r;
		req_ch.valid = 1'b0;
		req_ch.mode = MODE_ADD;
		req_ch.flow_addr = '0;
		req_ch.flow_port = '0;
		flow_pool[0] = '0;
		flow_pool[1] = '1;
		for (int i = 2; i < POOL; i++)
			flow_pool[i] = fresh_key();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty table, field extremes, each mode, freeing and reuse
		send_key(MODE_QUERY, '0);
		send_key(MODE_DEL, '1);
		send_key(MODE_ADD, '0);
		send_key(MODE_ADD, '0);
		send_key(MODE_ADD, '1);
		send_key(MODE_QUERY, '0);
		send_key(MODE_SPARE, '1);
		send_key(MODE_SPARE, 48'h1234_5678_9abc);
		send_key(MODE_DEL, '0);
		send_key(MODE_DEL, '0);
		send_key(MODE_QUERY, '0);
		send_key(MODE_DEL, '0);
		send_key(MODE_ADD, {32'haaaa_aaaa, 16'h5555});
		send_key(MODE_ADD, {32'h5555_5555, 16'haaaa});
		send_key(MODE_ADD, {32'haaaa_aaaa, 16'h5554});
		send_key(MODE_ADD, {32'haaaa_aaab, 16'h5555});
		send_key(MODE_QUERY, {32'haaaa_aaaa, 16'h5555});
		send_key(MODE_DEL, '1);
		send_key(MODE_ADD, '0);
		send_key(MODE_QUERY, {32'h5555_5555, 16'haaaa});

		// response side blocked while requests keep coming
		wait_drained();
		hold_now = 1'b1;
		repeat (8)
			send_key(MODE_ADD, flow_pool[$urandom_range(0, POOL - 1)]);

		send_mixed(350, 1'b0);

		// fill the table, then work on it while full
		idle_on = 1'b1;
		while (sb.occupancy < ENTRIES) begin
			if ($urandom_range(0, 99) < 15)
				send_key(MODE_QUERY, flow_pool[$urandom_range(0, POOL - 1)]);
			else
				send_key(MODE_ADD, fresh_key());
		end
		repeat (40) begin
			r = $urandom_range(0, 99);
			if (r < 50)
				send_key(MODE_ADD, fresh_key());
			else if (r < 70)
				send_key(MODE_ADD, flow_pool[$urandom_range(0, POOL - 1)]);
			else if (r < 90 && sb.occupancy > 0)
				send_key(MODE_DEL, sb.random_live_key());
			else
				send_key(MODE_QUERY, sb.random_live_key());
		end

		wait_drained();
		send_mixed((ITEMS - sent) / 2, 1'b1);
		wait_drained();
		if (sent < ITEMS)
			send_mixed(ITEMS - sent, 1'b1);

		wait_drained();
		repeat (2 * ENTRIES + 16) @(negedge clk);
		if (sb.pending_results.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending_results.size()));

		$display("covered %0d requests (add %0d, delete %0d, query %0d, unused mode %0d), %s",
			sent, mode_sent[MODE_ADD], mode_sent[MODE_DEL], mode_sent[MODE_QUERY],
			mode_sent[MODE_SPARE], $sformatf("%0d long response stalls, %0d drains",
			holds, drains));
		$display("results: %0d ok, %0d table full, %0d not present; peak %0d of %0d entries",
			sb.status_seen[ST_OK], sb.status_seen[ST_FULL], sb.status_seen[ST_ABSENT],
			sb.peak_occupancy, ENTRIES);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
